>>> hdl/imu_offset_deadband_integrator_assert.svh
// assertion macros for the imu offset/deadband integrator
`ifndef IMU_OFFSET_DEADBAND_INTEGRATOR_ASSERT_SVH
`define IMU_OFFSET_DEADBAND_INTEGRATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define IODI_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// next-cycle implication
`define IODI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define IODI_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define IODI_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

>>> hdl/iodi_pkg.sv
package iodi_pkg;

	localparam int AXIS_W     = 3;
	localparam int SAMPLE_W   = 16;
	localparam int DIFF_W     = 17;
	localparam int GAIN_W     = 16;
	localparam int BAND_W     = 16;
	localparam int TSTEP_W    = 16;
	localparam int SCALED_W   = 25;
	localparam int INTEGRAL_W = 32;
	localparam int GROUP_W    = 48;
	localparam int NUM_AXES   = 6;
	localparam int FRAC_SHIFT = 8;

	localparam int ACCUM_WIDTH_DEF = 48;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// APB
	localparam int APB_DATA_W = 64;
	localparam int APB_ADDR_W = 6;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_ACCEL_OFFSETS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GYRO_OFFSETS  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ACCEL_GAINS   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_GYRO_GAINS    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ACCEL_BAND    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_GYRO_BAND     = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_TIME_STEP     = 3'd6;

	localparam logic [GROUP_W-1:0] RST_ACCEL_GAINS = 48'h0100_0100_0100;
	localparam logic [GROUP_W-1:0] RST_GYRO_GAINS  = 48'h000F_0100_0100;
	localparam logic [BAND_W-1:0]  RST_ACCEL_BAND  = 16'd100;
	localparam logic [BAND_W-1:0]  RST_GYRO_BAND   = 16'd10;
	localparam logic [TSTEP_W-1:0] RST_TIME_STEP   = 16'd655;

	localparam logic [AXIS_W-1:0] AXIS_ACC_X = 3'd0;
	localparam logic [AXIS_W-1:0] AXIS_ACC_Y = 3'd1;
	localparam logic [AXIS_W-1:0] AXIS_ACC_Z = 3'd2;
	localparam logic [AXIS_W-1:0] AXIS_GYR_X = 3'd3;
	localparam logic [AXIS_W-1:0] AXIS_GYR_Y = 3'd4;
	localparam logic [AXIS_W-1:0] AXIS_GYR_Z = 3'd5;

	typedef struct packed {
		logic [GROUP_W-1:0] accel_offsets;
		logic [GROUP_W-1:0] gyro_offsets;
		logic [GROUP_W-1:0] accel_gains;
		logic [GROUP_W-1:0] gyro_gains;
		logic [BAND_W-1:0]  accel_band;
		logic [BAND_W-1:0]  gyro_band;
	} iodi_front_cfg_t;

	// one queued word: axis, scaled value, and whether the axis exists
	typedef struct packed {
		logic [AXIS_W-1:0]          axis;
		logic signed [SCALED_W-1:0] scaled;
		logic                       live;
	} iodi_entry_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [Q_CNT_W-1:0] count;
	} iodi_q_stat_t;

endpackage

>>> hdl/imu_offset_deadband_integrator.sv
// Path: an accepted word passes the front stage register, the queue, the product stage and the result register.
// Throughput: one word per cycle while the result port takes words; front and back run apart through a 4-deep queue.
// Rate limit: the per-axis accumulate-and-clamp loop in the back end.
// Reset (arst_n low): control state and all six accumulators cleared,
// configuration registers return to their default values.
`include "imu_offset_deadband_integrator_assert.svh"

module imu_offset_deadband_integrator #(
	parameter int ACCUM_WIDTH = iodi_pkg::ACCUM_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// APB configuration
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [iodi_pkg::APB_ADDR_W-1:0]         paddr,
	input  logic [iodi_pkg::APB_DATA_W-1:0]         pwdata,
	output logic [iodi_pkg::APB_DATA_W-1:0]         prdata,
	output logic                                    pready,
	// sample words
	input  logic                                    sample_valid,
	output logic                                    sample_ready,
	input  logic [iodi_pkg::AXIS_W-1:0]             axis,
	input  logic signed [iodi_pkg::SAMPLE_W-1:0]    raw_sample,
	// result words
	output logic                                    result_valid,
	input  logic                                    result_ready,
	output logic [iodi_pkg::AXIS_W-1:0]             axis_out,
	output logic signed [iodi_pkg::SCALED_W-1:0]    scaled_value,
	output logic signed [iodi_pkg::INTEGRAL_W-1:0]  integral
);
	import iodi_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers. Each sits at 8*index; only paddr[5:3]
	// is decoded. Writes to index 7 are dropped, reads return zero.
	// ---------------------------------------------------------------
	logic [GROUP_W-1:0] accel_offsets_q;
	logic [GROUP_W-1:0] gyro_offsets_q;
	logic [GROUP_W-1:0] accel_gains_q;
	logic [GROUP_W-1:0] gyro_gains_q;
	logic [BAND_W-1:0]  accel_band_q;
	logic [BAND_W-1:0]  gyro_band_q;
	logic [TSTEP_W-1:0] time_step_q;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_offsets_q <= '0;
			gyro_offsets_q  <= '0;
			accel_gains_q   <= RST_ACCEL_GAINS;
			gyro_gains_q    <= RST_GYRO_GAINS;
			accel_band_q    <= RST_ACCEL_BAND;
			gyro_band_q     <= RST_GYRO_BAND;
			time_step_q     <= RST_TIME_STEP;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ACCEL_OFFSETS: accel_offsets_q <= pwdata[GROUP_W-1:0];
				REG_GYRO_OFFSETS:  gyro_offsets_q  <= pwdata[GROUP_W-1:0];
				REG_ACCEL_GAINS:   accel_gains_q   <= pwdata[GROUP_W-1:0];
				REG_GYRO_GAINS:    gyro_gains_q    <= pwdata[GROUP_W-1:0];
				REG_ACCEL_BAND:    accel_band_q    <= pwdata[BAND_W-1:0];
				REG_GYRO_BAND:     gyro_band_q     <= pwdata[BAND_W-1:0];
				REG_TIME_STEP:     time_step_q     <= pwdata[TSTEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ACCEL_OFFSETS: prdata = APB_DATA_W'(accel_offsets_q);
			REG_GYRO_OFFSETS:  prdata = APB_DATA_W'(gyro_offsets_q);
			REG_ACCEL_GAINS:   prdata = APB_DATA_W'(accel_gains_q);
			REG_GYRO_GAINS:    prdata = APB_DATA_W'(gyro_gains_q);
			REG_ACCEL_BAND:    prdata = APB_DATA_W'(accel_band_q);
			REG_GYRO_BAND:     prdata = APB_DATA_W'(gyro_band_q);
			REG_TIME_STEP:     prdata = APB_DATA_W'(time_step_q);
			default:           prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Front: offset subtract, deadband, gain multiply.
	// ---------------------------------------------------------------
	iodi_front_cfg_t front_cfg;
	logic            q_push;
	logic            q_pop;
	iodi_entry_t     q_in;
	iodi_entry_t     q_head;
	iodi_q_stat_t    q_stat;

	assign front_cfg.accel_offsets = accel_offsets_q;
	assign front_cfg.gyro_offsets  = gyro_offsets_q;
	assign front_cfg.accel_gains   = accel_gains_q;
	assign front_cfg.gyro_gains    = gyro_gains_q;
	assign front_cfg.accel_band    = accel_band_q;
	assign front_cfg.gyro_band     = gyro_band_q;

	iodi_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (front_cfg),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.axis         (axis),
		.raw_sample   (raw_sample),
		.push         (q_push),
		.push_entry   (q_in),
		.q_full       (q_stat.full)
	);

	// decoupling queue between front and back
	iodi_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.pop        (q_pop),
		.head       (q_head),
		.stat       (q_stat)
	);

	// ---------------------------------------------------------------
	// Back: time-step multiply, saturating accumulate, result register.
	// ---------------------------------------------------------------
	iodi_back #(
		.ACCUM_WIDTH (ACCUM_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_step    (time_step_q),
		.q_empty      (q_stat.empty),
		.head         (q_head),
		.pop          (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.axis_out     (axis_out),
		.scaled_value (scaled_value),
		.integral     (integral)
	);

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`IODI_ASSERT_IMPLY(a_no_overflow, clk, arst_n, q_stat.full, !q_push, "queue push while full")
	`IODI_ASSERT_IMPLY(a_no_underflow, clk, arst_n, q_stat.empty, !q_pop, "queue pop while empty")
	`IODI_ASSERT_NEXT(a_count_up, clk, arst_n, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count did not advance")
	`IODI_ASSERT_IMPLY(a_dead_axis, clk, arst_n, result_valid && axis_out >= AXIS_W'(NUM_AXES), scaled_value == '0 && integral == '0, "nonzero result for missing axis")

endmodule

>>> hdl/iodi_front.sv
module iodi_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iodi_pkg::iodi_front_cfg_t         cfg,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  logic [iodi_pkg::AXIS_W-1:0]       axis,
	input  logic signed [iodi_pkg::SAMPLE_W-1:0] raw_sample,
	output logic                              push,
	output iodi_pkg::iodi_entry_t             push_entry,
	input  logic                              q_full
);
	import iodi_pkg::*;

	logic signed [SAMPLE_W-1:0] off;
	logic [GAIN_W-1:0]          gain;
	logic [BAND_W-1:0]          band;
	logic                       live;
	logic signed [DIFF_W-1:0]   diff;
	logic [DIFF_W-1:0]          mag;
	logic                       take;

	logic                       v_s1;
	logic [AXIS_W-1:0]          axis_s1;
	logic signed [DIFF_W-1:0]   diff_s1;
	logic [GAIN_W-1:0]          gain_s1;
	logic                       live_s1;

	logic signed [DIFF_W+GAIN_W:0] prod;

	// lane select per axis
	always_comb begin
		off  = '0;
		gain = '0;
		band = cfg.accel_band;
		live = 1'b1;
		unique case (axis)
			AXIS_ACC_X: begin
				off  = cfg.accel_offsets[15:0];
				gain = cfg.accel_gains[15:0];
			end
			AXIS_ACC_Y: begin
				off  = cfg.accel_offsets[31:16];
				gain = cfg.accel_gains[31:16];
			end
			AXIS_ACC_Z: begin
				off  = cfg.accel_offsets[47:32];
				gain = cfg.accel_gains[47:32];
			end
			AXIS_GYR_X: begin
				off  = cfg.gyro_offsets[15:0];
				gain = cfg.gyro_gains[15:0];
				band = cfg.gyro_band;
			end
			AXIS_GYR_Y: begin
				off  = cfg.gyro_offsets[31:16];
				gain = cfg.gyro_gains[31:16];
				band = cfg.gyro_band;
			end
			AXIS_GYR_Z: begin
				off  = cfg.gyro_offsets[47:32];
				gain = cfg.gyro_gains[47:32];
				band = cfg.gyro_band;
			end
			default: begin
				live = 1'b0;
			end
		endcase
	end

	assign diff = DIFF_W'(raw_sample) - DIFF_W'(off);
	assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	assign push         = v_s1 && !q_full;
	assign sample_ready = !v_s1 || push;
	assign take         = sample_valid && sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample_ready) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			axis_s1 <= axis;
			// strict compare: |diff| equal to band passes
			diff_s1 <= (mag < DIFF_W'(band) || !live) ? '0 : diff;
			gain_s1 <= gain;
			live_s1 <= live;
		end
	end

	// signed diff times unsigned Q8.8 gain, floor by 8
	assign prod = diff_s1 * $signed({1'b0, gain_s1});

	assign push_entry.axis   = axis_s1;
	assign push_entry.scaled = prod[FRAC_SHIFT+SCALED_W-1:FRAC_SHIFT];
	assign push_entry.live   = live_s1;

endmodule

>>> hdl/iodi_queue.sv
module iodi_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  iodi_pkg::iodi_entry_t  push_entry,
	input  logic                   pop,
	output iodi_pkg::iodi_entry_t  head,
	output iodi_pkg::iodi_q_stat_t stat
);
	import iodi_pkg::*;

	iodi_entry_t        mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			// push and pop together leave the count alone
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

>>> hdl/iodi_back.sv
module iodi_back #(
	parameter int ACCUM_WIDTH = iodi_pkg::ACCUM_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic [iodi_pkg::TSTEP_W-1:0]            time_step,
	input  logic                                    q_empty,
	input  iodi_pkg::iodi_entry_t                   head,
	output logic                                    pop,
	output logic                                    result_valid,
	input  logic                                    result_ready,
	output logic [iodi_pkg::AXIS_W-1:0]             axis_out,
	output logic signed [iodi_pkg::SCALED_W-1:0]    scaled_value,
	output logic signed [iodi_pkg::INTEGRAL_W-1:0]  integral
);
	import iodi_pkg::*;

	localparam int PROD_W = SCALED_W + TSTEP_W + 1;
	localparam int SUM_W  = ((ACCUM_WIDTH > PROD_W) ? ACCUM_WIDTH : PROD_W) + 1;

	localparam logic signed [SUM_W-1:0] ACC_MAX =
		SUM_W'({1'b0, {(ACCUM_WIDTH-1){1'b1}}});
	localparam logic signed [SUM_W-1:0] ACC_MIN = -ACC_MAX - SUM_W'(1);

	logic signed [ACCUM_WIDTH-1:0] acc_q [NUM_AXES];

	logic                       v_s1;
	logic [AXIS_W-1:0]          axis_s1;
	logic signed [SCALED_W-1:0] scaled_s1;
	logic                       live_s1;
	logic signed [PROD_W-1:0]   prod_s1;

	logic                          move;
	logic signed [ACCUM_WIDTH-1:0] acc_old;
	logic signed [SUM_W-1:0]       sum;
	logic signed [ACCUM_WIDTH-1:0] acc_new;
	logic signed [ACCUM_WIDTH-1:0] acc_shr;

	logic                        out_v_q;
	logic [AXIS_W-1:0]           axis_q;
	logic signed [SCALED_W-1:0]  scaled_q;
	logic signed [INTEGRAL_W-1:0] integral_q;

	assign move = v_s1 && (!out_v_q || result_ready);
	assign pop  = !q_empty && (!v_s1 || move);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!v_s1 || move) begin
			v_s1 <= pop;
		end
	end

	// product stage
	always_ff @(posedge clk) begin
		if (pop) begin
			axis_s1   <= head.axis;
			scaled_s1 <= head.scaled;
			live_s1   <= head.live;
			prod_s1   <= head.scaled * $signed({1'b0, time_step});
		end
	end

	// accumulate and clamp
	assign acc_old = live_s1 ? acc_q[axis_s1] : '0;
	assign sum     = SUM_W'(acc_old) + SUM_W'(prod_s1);

	always_comb begin
		priority if (sum > ACC_MAX) begin
			acc_new = ACC_MAX[ACCUM_WIDTH-1:0];
		end else if (sum < ACC_MIN) begin
			acc_new = ACC_MIN[ACCUM_WIDTH-1:0];
		end else begin
			acc_new = sum[ACCUM_WIDTH-1:0];
		end
	end

	assign acc_shr = acc_new >>> (ACCUM_WIDTH - INTEGRAL_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				acc_q[i] <= '0;
			end
		end else if (move && live_s1) begin
			acc_q[axis_s1] <= acc_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (!out_v_q || result_ready) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			axis_q     <= axis_s1;
			scaled_q   <= live_s1 ? scaled_s1 : '0;
			integral_q <= live_s1 ? acc_shr[INTEGRAL_W-1:0] : '0;
		end
	end

	assign result_valid = out_v_q;
	assign axis_out     = axis_q;
	assign scaled_value = scaled_q;
	assign integral     = integral_q;

endmodule

>>> tb/sv/tb_imu_offset_deadband_integrator.sv
`timescale 1ns / 1ps

module tb_imu_offset_deadband_integrator;
	import iodi_pkg::*;

	// ---------------------------------------------------------------------
	// Local constants
	// ---------------------------------------------------------------------
	localparam int ACC_W     = ACCUM_WIDTH_DEF;
	localparam int ACC_SHIFT = ACC_W - INTEGRAL_W;   // integral = acc >>> this
	localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	localparam int NUM_REGS = REG_TIME_STEP + 1;
	// index 7 decodes to no register; a write there must be dropped
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	localparam logic [63:0] GROUP_MASK = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0] BAND_MASK  = 64'h0000_0000_0000_FFFF;

	// axis codes that name no sensor
	localparam logic [AXIS_W-1:0] AXIS_SPARE_A = 3'd6;
	localparam logic [AXIS_W-1:0] AXIS_SPARE_B = 3'd7;

	// phase plan: each phase loads a new register set, then streams words
	localparam int NUM_PHASES     = 8;
	localparam int PH_ZERO_GAIN   = 0;   // accel gains zero, gyro deadband zero
	localparam int PH_WIDE_BAND   = 2;   // deadbands at their top value
	localparam int PH_SATURATE    = 4;   // gains and time step maxed, deadbands zero, drive accumulators to the rails
	localparam int RANDOM_WORDS   = 153;
	localparam int SATURATE_WORDS = 560;

	// ---------------------------------------------------------------------
	// Types
	// ---------------------------------------------------------------------
	typedef struct packed {
		logic [AXIS_W-1:0]          axis;
		logic signed [SAMPLE_W-1:0] raw;
	} sample_t;

	typedef struct packed {
		logic [AXIS_W-1:0]            axis;
		logic signed [SCALED_W-1:0]   scaled;
		logic signed [INTEGRAL_W-1:0] integral;
	} result_t;

	// ---------------------------------------------------------------------
	// DUT signals; every input has a known value from time zero
	// ---------------------------------------------------------------------
	logic                         clk;
	logic                         arst_n       = 1'b0;
	logic                         psel         = 1'b0;
	logic                         penable      = 1'b0;
	logic                         pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0]        paddr        = '0;
	logic [APB_DATA_W-1:0]        pwdata       = '0;
	logic [APB_DATA_W-1:0]        prdata;
	logic                         pready;
	logic                         sample_valid = 1'b0;
	logic                         sample_ready;
	logic [AXIS_W-1:0]            axis         = '0;
	logic signed [SAMPLE_W-1:0]   raw_sample   = '0;
	logic                         result_valid;
	logic                         result_ready = 1'b0;
	logic [AXIS_W-1:0]            axis_out;
	logic signed [SCALED_W-1:0]   scaled_value;
	logic signed [INTEGRAL_W-1:0] integral;

	imu_offset_deadband_integrator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.axis         (axis),
		.raw_sample   (raw_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.axis_out     (axis_out),
		.scaled_value (scaled_value),
		.integral     (integral)
	);

	// ---------------------------------------------------------------------
	// Scoreboard state
	// ---------------------------------------------------------------------
	sample_t     sample_backlog[$];     // words waiting for the driver
	result_t     pending_results[$];    // predicted results, oldest first
	logic [63:0] cfg_shadow [0:NUM_REGS-1];
	longint      axis_acc [0:NUM_AXES-1];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int words_issued  = 0;   // pushed into the backlog
	int words_taken   = 0;   // accepted by the DUT
	int results_seen  = 0;
	int errors        = 0;
	int zeroed_count  = 0;   // predictions killed by the deadband
	int clamp_count   = 0;   // predictions that hit an accumulator rail
	int settings_done = 0;

	// ---------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Predictor: offset, deadband, Q8.8 gain, Q0.16 integrate with clamp.
	// Updates the per-axis accumulator copy and returns the result word.
	// ---------------------------------------------------------------------
	function automatic result_t integrate_sample(logic [AXIS_W-1:0] ax,
			logic signed [SAMPLE_W-1:0] raw);
		result_t     r;
		int          grp;
		int          lane;
		logic [15:0] off;
		logic [15:0] gain;
		logic [15:0] band;
		logic [15:0] tstep;
		longint      diff;
		longint      mag;
		longint      scaled;
		longint      acc;
		longint      top;

		r.axis     = ax;
		r.scaled   = '0;
		r.integral = '0;
		// spare axis codes: zero result, no state touched
		if (ax >= NUM_AXES)
			return r;

		grp   = ax / 3;
		lane  = (ax % 3) * 16;
		off   = cfg_shadow[REG_ACCEL_OFFSETS + grp][lane +: 16];
		gain  = cfg_shadow[REG_ACCEL_GAINS + grp][lane +: 16];
		band  = cfg_shadow[REG_ACCEL_BAND + grp][15:0];
		tstep = cfg_shadow[REG_TIME_STEP][15:0];

		// 17-bit signed difference; strict compare, so |diff| == band survives
		diff = longint'(raw) - longint'($signed(off));
		mag  = (diff < 0) ? -diff : diff;
		if (mag < longint'(band)) begin
			diff = 0;
			zeroed_count++;
		end

		// >>> on a signed value floors toward minus infinity
		scaled = (diff * longint'(gain)) >>> FRAC_SHIFT;

		// no 64-bit overflow here: |acc| < 2^47, |product| < 2^41
		acc = axis_acc[ax] + scaled * longint'(tstep);
		if (acc > ACC_MAX) begin
			acc = ACC_MAX;
			clamp_count++;
		end else if (acc < ACC_MIN) begin
			acc = ACC_MIN;
			clamp_count++;
		end
		axis_acc[ax] = acc;

		top        = acc >>> ACC_SHIFT;
		r.scaled   = scaled[SCALED_W-1:0];
		r.integral = top[INTEGRAL_W-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Driver: holds valid/payload until accepted, predicts on acceptance,
	// and idles at random per send_idle_pct.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : drive_samples
		sample_t nxt;
		logic    fire;

		if (arst_n) begin
			fire = sample_valid && sample_ready;
			if (fire) begin
				pending_results.push_back(integrate_sample(axis, raw_sample));
				words_taken++;
			end
			// only move on when the current word is gone (or there is none)
			if (!sample_valid || fire) begin
				if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = sample_backlog.pop_front();
					sample_valid <= 1'b1;
					axis         <= nxt.axis;
					raw_sample   <= nxt.raw;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: compares every accepted result word against the oldest
	// prediction; stalls the result port at random per recv_idle_pct.
	// ---------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		result_t want;

		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: result word with nothing predicted: axis %0d scaled %0d integral %0d",
						$time, axis_out, scaled_value, integral);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (axis_out !== want.axis) begin
						$display("%0t: axis_out expected %0d got %0d", $time, want.axis, axis_out);
						errors++;
					end
					if (scaled_value !== want.scaled) begin
						$display("%0t: scaled_value (axis %0d) expected %0d got %0d",
							$time, want.axis, want.scaled, scaled_value);
						errors++;
					end
					if (integral !== want.integral) begin
						$display("%0t: integral (axis %0d) expected %0d got %0d",
							$time, want.axis, want.integral, integral);
						errors++;
					end
				end
			end
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------
	task automatic queue_sample(input logic [AXIS_W-1:0] ax, input logic [15:0] raw);
		sample_t s;
		s.axis = ax;
		s.raw  = raw;
		sample_backlog.push_back(s);
		words_issued++;
	endtask

	// Random word that leans on the interesting spots: words that land just
	// around the deadband edge, rail values, and the two spare axis codes.
	task automatic queue_random_sample();
		logic [AXIS_W-1:0] ax;
		int                grp;
		int                lane;
		int                v;
		int                edge_val;
		logic [15:0]       off;

		if ($urandom_range(99) < 5)
			ax = $urandom_range(AXIS_SPARE_B, AXIS_SPARE_A);
		else
			ax = $urandom_range(NUM_AXES - 1, 0);
		grp  = (ax < NUM_AXES) ? ax / 3 : 0;
		lane = (ax < NUM_AXES) ? (ax % 3) * 16 : 0;
		off  = cfg_shadow[REG_ACCEL_OFFSETS + grp][lane +: 16];

		case ($urandom_range(9))
			0: v = $urandom_range(1) ? 32767 : -32768;
			1, 2, 3: begin
				// offset +/- (deadband + small delta), wrapped to 16 bits
				edge_val = int'(cfg_shadow[REG_ACCEL_BAND + grp][15:0])
					+ $urandom_range(4) - 2;
				v = int'($signed(off)) + ($urandom_range(1) ? edge_val : -edge_val);
			end
			default: v = $urandom_range(16'hFFFF);
		endcase
		queue_sample(ax, v[15:0]);
	endtask

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'h0100;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_band();
		case ($urandom_range(5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2, 3:    return 16'($urandom_range(300));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_offset();
		return ($urandom_range(4) == 0) ? 16'h0000 : 16'($urandom);
	endfunction

	// APB write: setup cycle, then access until pready; the register takes
	// the value at the edge that ends the access cycle.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx < NUM_REGS)
			cfg_shadow[idx] = value & ((idx < REG_ACCEL_BAND) ? GROUP_MASK : BAND_MASK);
	endtask

	// New register set for one phase. Junk in the unused upper bits checks
	// that the DUT masks each register to its width.
	task automatic load_config(input int phase);
		logic [63:0] v [0:NUM_REGS-1];
		int          i;

		v[REG_ACCEL_OFFSETS] = {16'($urandom), pick_offset(), pick_offset(), pick_offset()};
		v[REG_GYRO_OFFSETS]  = {16'($urandom), pick_offset(), pick_offset(), pick_offset()};
		v[REG_ACCEL_GAINS]   = {16'($urandom), pick_gain(), pick_gain(), pick_gain()};
		v[REG_GYRO_GAINS]    = {16'($urandom), pick_gain(), pick_gain(), pick_gain()};
		v[REG_ACCEL_BAND]    = {48'($urandom), pick_band()};
		v[REG_GYRO_BAND]     = {48'($urandom), pick_band()};
		case ($urandom_range(3))
			0:       v[REG_TIME_STEP] = 64'h0;
			1:       v[REG_TIME_STEP] = 64'hFFFF;
			default: v[REG_TIME_STEP] = {48'($urandom), 16'($urandom)};
		endcase

		case (phase)
			PH_ZERO_GAIN: begin
				v[REG_ACCEL_GAINS] = 64'h0;
				v[REG_GYRO_BAND]   = 64'h0;
			end
			PH_WIDE_BAND: begin
				v[REG_ACCEL_BAND] = 64'hFFFF;
				v[REG_GYRO_BAND]  = 64'hFFFF;
			end
			PH_SATURATE: begin
				// X lanes at -32768, Y lanes at +32767: rail samples give |diff| = 65535
				v[REG_ACCEL_OFFSETS] = {16'($urandom), 16'($urandom), 16'h7FFF, 16'h8000};
				v[REG_GYRO_OFFSETS]  = {16'($urandom), 16'($urandom), 16'h7FFF, 16'h8000};
				v[REG_ACCEL_GAINS]   = 64'hFFFF_FFFF_FFFF;
				v[REG_GYRO_GAINS]    = 64'hFFFF_FFFF_FFFF;
				v[REG_ACCEL_BAND]    = 64'h0;
				v[REG_GYRO_BAND]     = 64'h0;
				v[REG_TIME_STEP]     = 64'hFFFF;
			end
			default: ;
		endcase

		for (i = 0; i < NUM_REGS; i++)
			write_reg(i[REG_IDX_W-1:0], v[i]);
		if (phase == PH_ZERO_GAIN)
			write_reg(REG_UNMAPPED, {$urandom, $urandom});
		settings_done++;
	endtask

	// Block is idle once every issued word went in and every result came out.
	task automatic wait_drained();
		while (words_taken != words_issued || pending_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin : run_test
		int p;
		int i;
		int v;

		cfg_shadow[REG_ACCEL_OFFSETS] = 64'h0;
		cfg_shadow[REG_GYRO_OFFSETS]  = 64'h0;
		cfg_shadow[REG_ACCEL_GAINS]   = 64'(RST_ACCEL_GAINS);
		cfg_shadow[REG_GYRO_GAINS]    = 64'(RST_GYRO_GAINS);
		cfg_shadow[REG_ACCEL_BAND]    = 64'(RST_ACCEL_BAND);
		cfg_shadow[REG_GYRO_BAND]     = 64'(RST_GYRO_BAND);
		cfg_shadow[REG_TIME_STEP]     = 64'(RST_TIME_STEP);
		for (i = 0; i < NUM_AXES; i++)
			axis_acc[i] = 0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 36;
		recv_idle_pct = 65;

		// directed words against the reset register values
		queue_sample(AXIS_ACC_X, 16'sh7FFF);
		queue_sample(AXIS_ACC_Y, 16'sh8000);
		queue_sample(AXIS_ACC_Z, 16'sh0000);
		queue_sample(AXIS_GYR_X, 16'sh7FFF);
		queue_sample(AXIS_GYR_Y, 16'sh8000);
		queue_sample(AXIS_GYR_Z, -16'sd1000);    // gain 15/256: floors to -59
		queue_sample(AXIS_GYR_Z, 16'sh7FFF);
		queue_sample(AXIS_ACC_X, 16'sd99);       // just inside the accel deadband
		queue_sample(AXIS_ACC_X, 16'sd100);      // equal to the deadband: passes
		queue_sample(AXIS_ACC_Y, -16'sd99);
		queue_sample(AXIS_ACC_Y, -16'sd100);
		queue_sample(AXIS_GYR_X, 16'sd9);        // gyro deadband edge
		queue_sample(AXIS_GYR_X, 16'sd10);
		queue_sample(AXIS_GYR_Y, -16'sd10);
		queue_sample(AXIS_GYR_Y, -16'sd9);
		queue_sample(AXIS_SPARE_A, 16'sd1234);   // no such axis: zeros, no state
		queue_sample(AXIS_SPARE_B, 16'sh8000);
		queue_sample(AXIS_ACC_Z, 16'sh8000);
		wait_drained();

		for (p = 0; p < NUM_PHASES; p++) begin
			// idle profile: sender-light first, then receiver-light, then none
			if (p < 3) begin
				send_idle_pct = 36;
				recv_idle_pct = 65;
			end else if (p < 6) begin
				send_idle_pct = 65;
				recv_idle_pct = 36;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			load_config(p);

			if (p == PH_SATURATE) begin
				// First half pushes X axes up hard, second half pushes Y axes
				// down hard; ~130 such words reach a rail, so both rails get hit.
				// One word in ten is plain noise.
				for (i = 0; i < SATURATE_WORDS; i++) begin
					if ($urandom_range(9) == 0) begin
						queue_random_sample();
					end else if (i < SATURATE_WORDS / 2) begin
						v = $urandom_range(32767, 32000);
						queue_sample(i[0] ? AXIS_ACC_X : AXIS_GYR_X, v[15:0]);
					end else begin
						v = -$urandom_range(32768, 32000);
						queue_sample(i[0] ? AXIS_ACC_Y : AXIS_GYR_Y, v[15:0]);
					end
				end
			end else begin
				for (i = 0; i < RANDOM_WORDS; i++)
					queue_random_sample();
			end
			wait_drained();
		end

		// let any stray result word surface before judging
		repeat (8) @(posedge clk);

		$display("Streamed %0d sample words through %0d register settings, checked %0d results",
			words_taken, settings_done + 1, results_seen);
		$display("Predicted %0d deadband zeroes and %0d accumulator clamps",
			zeroed_count, clamp_count);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run (~2k words)
	initial begin
		#2_000_000;
		$display("Timeout: %0d of %0d words accepted, %0d results outstanding",
			words_taken, words_issued, pending_results.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
